// File: design/wbss_pkg.sv
// Shared constants, types and configuration codes of the wildcard byte signature scanner.
`timescale 1ns / 1ps
`default_nettype none

package wbss_pkg;

    localparam int MAX_PATTERN_BYTES = 32;
    localparam int ADDRESS_BITS      = 48;
    localparam int SIG_REG_BYTES     = 32;

    // Longest signature that both the window and the signature registers can hold.
    localparam int LIM_BYTES = (MAX_PATTERN_BYTES < SIG_REG_BYTES) ?
                               MAX_PATTERN_BYTES : SIG_REG_BYTES;

    localparam int LEN_W    = 6;
    localparam int BV_W     = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int WIN_IW   = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam int CFG_W    = 64;
    localparam int CFG_IW   = 3;
    localparam int OFFSET_W = 32;

    localparam int IN_TDATA_W  = ((8 + ADDRESS_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((ADDRESS_BITS + 7) / 8) * 8;

    localparam logic [CFG_IW-1:0] CFG_PATTERN_0   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_PATTERN_1   = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_PATTERN_2   = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_PATTERN_3   = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_CARE_MASK   = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_LENGTH      = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_OFFSET      = 3'd6;
    localparam logic [CFG_IW-1:0] CFG_REPORT_ALL  = 3'd7;

    typedef logic [MAX_PATTERN_BYTES-1:0][7:0] t_window;

    typedef struct packed {
        logic [SIG_REG_BYTES*8-1:0] pattern;
        logic [SIG_REG_BYTES-1:0]   care;
        logic [LEN_W-1:0]           len;      // effective length, 1 to LIM_BYTES
        logic signed [OFFSET_W-1:0] offset;
        logic                       report_all;
    } t_cfg;

    typedef struct packed {
        t_window                 win;         // entry 0 is the newest byte
        logic [BV_W-1:0]         bytes_valid;
        logic [ADDRESS_BITS-1:0] addr;
        logic                    last;
    } t_win_item;

endpackage

`default_nettype wire

// File: design/wildcard_byte_signature_scan.sv
// Top level of the wildcard byte signature scanner.
`timescale 1ns / 1ps
`default_nettype none

// Scans a stream of memory bytes for a signature of up to 32 bytes with
// per-byte wildcards, set through the write port. One item (one byte with its
// address) is accepted every clock cycle unless the result side stalls; its
// result, if any, comes out of the result register, after the input register
// with the shift window and the combinational masked compare. A back-pressured
// result holds one more item in the input stage before the input is stalled. A
// match reports the address of its first byte plus the signed offset; the end
// of a region with no match gives one not-found result. Registers are to be
// written only while the block is idle.
module wildcard_byte_signature_scan (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [wbss_pkg::CFG_IW-1:0]        i_cfg_index,
    input  wire logic [wbss_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire logic                               i_s_tvalid,
    output      logic                               o_s_tready,
    input  wire logic [wbss_pkg::IN_TDATA_W-1:0]    i_s_tdata,   // data_byte, byte_address
    input  wire logic                               i_s_tlast,   // region_last
    output      logic                               o_m_tvalid,
    input  wire logic                               i_m_tready,
    output      logic [wbss_pkg::OUT_TDATA_W-1:0]   o_m_tdata,   // match_address
    output      logic                               o_m_tuser,   // found
    output      logic                               o_m_tlast    // region_done
);

    wbss_pkg::t_cfg                    cfg;
    wbss_pkg::t_win_item               win_item;
    logic                              win_valid;
    logic                              match_ready;
    logic [wbss_pkg::ADDRESS_BITS-1:0] match_addr;

    wbss_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    wbss_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_byte  (i_s_tdata[7:0]),
        .i_addr  (i_s_tdata[8 +: wbss_pkg::ADDRESS_BITS]),
        .i_last  (i_s_tlast),
        .o_valid (win_valid),
        .i_ready (match_ready),
        .o_item  (win_item)
    );

    wbss_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (win_valid),
        .o_ready (match_ready),
        .i_item  (win_item),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_found (o_m_tuser),
        .o_addr  (match_addr),
        .o_done  (o_m_tlast)
    );

    assign o_m_tdata = wbss_pkg::OUT_TDATA_W'(match_addr);

endmodule

`default_nettype wire

// File: design/wbss_cfg_regs.sv
// Configuration register file with the effective signature length.
`timescale 1ns / 1ps
`default_nettype none

module wbss_cfg_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [wbss_pkg::CFG_IW-1:0] i_cfg_index,
    input  wire logic [wbss_pkg::CFG_W-1:0]  i_cfg_data,
    output wbss_pkg::t_cfg                   o_cfg
);

    logic [wbss_pkg::SIG_REG_BYTES*8-1:0] r_pattern;
    logic [wbss_pkg::SIG_REG_BYTES-1:0]   r_care;
    logic [wbss_pkg::LEN_W-1:0]           r_len;
    logic signed [wbss_pkg::OFFSET_W-1:0] r_offset;
    logic                                 r_report_all;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern    <= '0;
            r_care       <= '0;
            r_len        <= wbss_pkg::LEN_W'(1);
            r_offset     <= '0;
            r_report_all <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                wbss_pkg::CFG_PATTERN_0:  r_pattern[0*64 +: 64] <= i_cfg_data;
                wbss_pkg::CFG_PATTERN_1:  r_pattern[1*64 +: 64] <= i_cfg_data;
                wbss_pkg::CFG_PATTERN_2:  r_pattern[2*64 +: 64] <= i_cfg_data;
                wbss_pkg::CFG_PATTERN_3:  r_pattern[3*64 +: 64] <= i_cfg_data;
                wbss_pkg::CFG_CARE_MASK:  r_care <= i_cfg_data[wbss_pkg::SIG_REG_BYTES-1:0];
                wbss_pkg::CFG_LENGTH:     r_len <= i_cfg_data[wbss_pkg::LEN_W-1:0];
                wbss_pkg::CFG_OFFSET:     r_offset <= i_cfg_data[wbss_pkg::OFFSET_W-1:0];
                wbss_pkg::CFG_REPORT_ALL: r_report_all <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // A length of zero acts as one; anything longer than the window is cut to it.
    always_comb begin
        o_cfg.pattern    = r_pattern;
        o_cfg.care       = r_care;
        o_cfg.offset     = r_offset;
        o_cfg.report_all = r_report_all;
        if (r_len == '0) begin
            o_cfg.len = wbss_pkg::LEN_W'(1);
        end else if (r_len > wbss_pkg::LEN_W'(wbss_pkg::LIM_BYTES)) begin
            o_cfg.len = wbss_pkg::LEN_W'(wbss_pkg::LIM_BYTES);
        end else begin
            o_cfg.len = r_len;
        end
    end

endmodule

`default_nettype wire

// File: design/wbss_window.sv
// Input register stage: shift window of recent bytes and region byte count.
`timescale 1ns / 1ps
`default_nettype none

module wbss_window (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output      logic                            o_ready,
    input  wire logic [7:0]                      i_byte,
    input  wire logic [wbss_pkg::ADDRESS_BITS-1:0] i_addr,
    input  wire logic                            i_last,
    output      logic                            o_valid,
    input  wire logic                            i_ready,
    output wbss_pkg::t_win_item                  o_item
);

    logic                  r_valid;
    wbss_pkg::t_win_item   r_item;
    wbss_pkg::t_window     n_win;
    logic [wbss_pkg::BV_W-1:0] n_bv;
    logic [wbss_pkg::BV_W-1:0] base_bv;
    logic                  accept;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // The window and count stay behind after an item leaves, as the base for the
    // next one; after the region's last byte the count starts again from zero.
    // Window entries past the count are never compared, so they are not cleared.
    always_comb begin
        base_bv = r_item.last ? '0 : r_item.bytes_valid;
        n_bv    = (base_bv < wbss_pkg::BV_W'(wbss_pkg::MAX_PATTERN_BYTES)) ?
                  base_bv + 1'b1 : base_bv;
        n_win    = r_item.win;
        n_win[0] = i_byte;
        for (int k = 1; k < wbss_pkg::MAX_PATTERN_BYTES; k++) begin
            n_win[k] = r_item.win[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid            <= 1'b0;
            r_item.bytes_valid <= '0;
            r_item.last        <= 1'b0;
        end else begin
            if (accept) begin
                r_valid            <= 1'b1;
                r_item.win         <= n_win;
                r_item.bytes_valid <= n_bv;
                r_item.addr        <= i_addr;
                r_item.last        <= i_last;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// File: design/wbss_match.sv
// Masked signature compare, overlap and first-match control, and the result register.
`timescale 1ns / 1ps
`default_nettype none

module wbss_match (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire wbss_pkg::t_cfg                    i_cfg,
    input  wire logic                              i_valid,
    output      logic                              o_ready,
    input  wire wbss_pkg::t_win_item               i_item,
    output      logic                              o_valid,
    input  wire logic                              i_ready,
    output      logic                              o_found,
    output      logic [wbss_pkg::ADDRESS_BITS-1:0] o_addr,
    output      logic                              o_done
);

    logic [wbss_pkg::LEN_W-1:0]        r_skip;
    logic                              r_seen;
    logic                              r_out_valid;
    logic                              r_found;
    logic [wbss_pkg::ADDRESS_BITS-1:0] r_addr;
    logic                              r_done;

    logic                              fire;
    logic                              candidate;
    logic                              mismatch;
    logic                              hit;
    logic                              has_result;
    logic [wbss_pkg::LEN_W-1:0]        idx;
    logic [wbss_pkg::LEN_W-1:0]        n_skip;
    logic                              n_seen;
    logic [wbss_pkg::ADDRESS_BITS-1:0] n_addr;

    assign o_ready = !r_out_valid || i_ready;
    assign fire    = i_valid && o_ready;

    // Signature byte i lines up with window entry len-1-i.
    always_comb begin
        mismatch = 1'b0;
        idx      = '0;
        for (int i = 0; i < wbss_pkg::LIM_BYTES; i++) begin
            idx = i_cfg.len - 1'b1 - wbss_pkg::LEN_W'(i);
            if (wbss_pkg::LEN_W'(i) < i_cfg.len && i_cfg.care[i] &&
                i_item.win[idx[wbss_pkg::WIN_IW-1:0]] != i_cfg.pattern[8*i +: 8]) begin
                mismatch = 1'b1;
            end
        end
    end

    always_comb begin
        candidate = (r_skip == '0) &&
                    ({{(wbss_pkg::LEN_W + 1){1'b0}}, i_item.bytes_valid} >=
                     {{(wbss_pkg::BV_W + 1){1'b0}}, i_cfg.len}) &&
                    (i_cfg.report_all || !r_seen);
        hit        = candidate && !mismatch;
        has_result = hit || (i_item.last && !r_seen);
        n_addr     = i_item.addr - wbss_pkg::ADDRESS_BITS'(i_cfg.len - 1'b1)
                     + wbss_pkg::ADDRESS_BITS'(i_cfg.offset);

        // A reported match bars the next len-1 bytes from ending another one.
        if (i_item.last) begin
            n_skip = '0;
        end else if (r_skip != '0) begin
            n_skip = r_skip - 1'b1;
        end else if (hit) begin
            n_skip = i_cfg.len - 1'b1;
        end else begin
            n_skip = r_skip;
        end
        n_seen = (hit || r_seen) && !i_item.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip      <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= fire && has_result;
            if (fire) begin
                r_skip <= n_skip;
                r_seen <= n_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_found <= hit;
            r_addr  <= hit ? n_addr : '0;
            r_done  <= i_item.last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_found = r_found;
    assign o_addr  = r_addr;
    assign o_done  = r_done;

endmodule

`default_nettype wire

// File: tb/tb_wildcard_byte_signature_scan.sv
// Self-checking testbench of the wildcard byte signature scanner.
`timescale 1ns / 1ps

module tb_wildcard_byte_signature_scan;

    localparam int RANDOM_ITEMS   = 800;
    localparam int DRAIN_CYCLES   = 6;
    localparam int END_CYCLES     = 12;
    localparam int WATCHDOG_LIMIT = 1000;

    localparam int RX_FREE  = 0;
    localparam int RX_COIN  = 1;
    localparam int RX_COMB  = 2;
    localparam int RX_BLOCK = 3;

    typedef logic [wbss_pkg::ADDRESS_BITS-1:0] t_addr;

    typedef struct packed {
        logic  found;
        t_addr addr;
        logic  done;
    } t_scan_result;

    // Tracks the scanner's registers and window, and holds the results still owed.
    class scan_scoreboard;
        logic [63:0] sig_words [4];
        logic [31:0] care_bits;
        logic [5:0]  len_reg;
        logic [31:0] offset_reg;
        logic        report_every;
        logic [7:0]  window [wbss_pkg::MAX_PATTERN_BYTES];
        int unsigned fill;
        int unsigned skip_left;
        bit          matched;
        t_scan_result owed_q [$];
        int unsigned mismatches;
        int unsigned found_seen;
        int unsigned missing_seen;

        function new();
            foreach (sig_words[i]) sig_words[i] = '0;
            care_bits    = '0;
            len_reg      = 6'd1;
            offset_reg   = '0;
            report_every = 1'b0;
            mismatches   = 0;
            found_seen   = 0;
            missing_seen = 0;
            clear_region();
        endfunction

        function void clear_region();
            foreach (window[i]) window[i] = 8'h00;
            fill      = 0;
            skip_left = 0;
            matched   = 1'b0;
        endfunction

        function int unsigned eff_len();
            int unsigned n;
            n = (len_reg == 0) ? 1 : len_reg;
            if (n > wbss_pkg::LIM_BYTES) n = wbss_pkg::LIM_BYTES;
            return n;
        endfunction

        function logic [7:0] sig_byte(int unsigned i);
            return sig_words[i / 8][(i % 8) * 8 +: 8];
        endfunction

        function void write_reg(logic [wbss_pkg::CFG_IW-1:0] idx,
                                logic [wbss_pkg::CFG_W-1:0] val);
            case (idx)
                wbss_pkg::CFG_PATTERN_0:  sig_words[0] = val;
                wbss_pkg::CFG_PATTERN_1:  sig_words[1] = val;
                wbss_pkg::CFG_PATTERN_2:  sig_words[2] = val;
                wbss_pkg::CFG_PATTERN_3:  sig_words[3] = val;
                wbss_pkg::CFG_CARE_MASK:  care_bits    = val[31:0];
                wbss_pkg::CFG_LENGTH:     len_reg      = val[5:0];
                wbss_pkg::CFG_OFFSET:     offset_reg   = val[31:0];
                wbss_pkg::CFG_REPORT_ALL: report_every = val[0];
                default: ;
            endcase
        endfunction

        function void note_byte(logic [7:0] b, t_addr a, logic last);
            int unsigned n;
            int unsigned i;
            bit hit;
            t_scan_result r;
            n   = eff_len();
            hit = 1'b0;
            for (i = wbss_pkg::MAX_PATTERN_BYTES - 1; i > 0; i--) window[i] = window[i-1];
            window[0] = b;
            if (fill < wbss_pkg::MAX_PATTERN_BYTES) fill++;
            if (skip_left > 0) begin
                skip_left--;
            end else if (fill >= n && (report_every || !matched)) begin
                hit = 1'b1;
                // Signature byte 0 lines up with the oldest byte of the match.
                for (i = 0; i < n; i++)
                    if (care_bits[i] && window[n-1-i] != sig_byte(i)) hit = 1'b0;
            end
            if (hit) begin
                r.found = 1'b1;
                r.addr  = a - t_addr'(n - 1)
                          + {{(wbss_pkg::ADDRESS_BITS-32){offset_reg[31]}}, offset_reg};
                r.done  = last;
                owed_q  = {owed_q, r};
                matched   = 1'b1;
                skip_left = n - 1;
            end else if (last && !matched) begin
                r.found = 1'b0;
                r.addr  = '0;
                r.done  = 1'b1;
                owed_q  = {owed_q, r};
            end
            if (last) clear_region();
        endfunction

        function void check_result(logic found, t_addr a, logic done);
            t_scan_result want;
            if (found) found_seen++;
            else missing_seen++;
            if (owed_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: found=%0b addr=%h done=%0b", found, a, done);
                return;
            end
            want = owed_q.pop_front();
            if (want.found !== found || want.addr !== a || want.done !== done) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"Mismatch: expected found=%0b addr=%h done=%0b, ",
                              "got found=%0b addr=%h done=%0b"},
                             want.found, want.addr, want.done, found, a, done);
            end
        endfunction
    endclass

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [wbss_pkg::CFG_IW-1:0]      i_cfg_index;
    logic [wbss_pkg::CFG_W-1:0]       i_cfg_data;
    logic                             i_s_tvalid;
    logic                             o_s_tready;
    logic [wbss_pkg::IN_TDATA_W-1:0]  i_s_tdata;   // data_byte, byte_address
    logic                             i_s_tlast;   // region_last
    logic                             o_m_tvalid;
    logic                             i_m_tready;
    logic [wbss_pkg::OUT_TDATA_W-1:0] o_m_tdata;   // match_address
    logic                             o_m_tuser;   // found
    logic                             o_m_tlast;   // region_done

    wildcard_byte_signature_scan DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    scan_scoreboard sb;
    logic [7:0]     region_bytes [$];
    t_addr          next_addr;
    bit             in_region;
    int unsigned    burst_left;
    int unsigned    items_sent;
    int unsigned    regions_run;
    int unsigned    settings_run;
    int unsigned    quiet_cycles;
    int unsigned    rx_mode;
    int unsigned    rx_left;
    int unsigned    rx_tick;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Result side: the stall pattern is picked anew at random times.
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(RX_FREE, RX_BLOCK);
            rx_left <= $urandom_range(20, 150);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            RX_FREE:  i_m_tready <= 1'b1;
            RX_COIN:  i_m_tready <= ($urandom_range(0, 3) != 0);
            RX_COMB:  i_m_tready <= ((rx_tick % 7) < 4);
            default:  i_m_tready <= ((rx_tick % 32) >= 24);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tuser, o_m_tdata[wbss_pkg::ADDRESS_BITS-1:0], o_m_tlast);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Timeout: nothing moved for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, sb.owed_q.size());
            $display("FAIL wildcard_byte_signature_scan");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Each task starts and ends at a falling edge.
    task automatic send_byte(logic [7:0] b, t_addr a, logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                      : $urandom_range(1, 40);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {a, b};
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_byte(b, a, last);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_region(bit close);
        int unsigned k;
        for (k = 0; k < region_bytes.size(); k++) begin
            send_byte(region_bytes[k], next_addr, close && (k == region_bytes.size() - 1));
            next_addr++;
        end
        if (close) regions_run++;
        in_region = !close;
    endtask

    // Waits until the scanner has nothing in flight.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.owed_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [wbss_pkg::CFG_IW-1:0] idx,
                             logic [wbss_pkg::CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        @(negedge i_clk);
    endtask

    // Narrow registers get random upper bits, which the scanner must ignore.
    task automatic apply_config(logic [63:0] w0, logic [63:0] w1, logic [63:0] w2,
                                logic [63:0] w3, logic [31:0] mask, logic [5:0] len,
                                logic [31:0] off, logic rep);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        settle();
        write_reg(wbss_pkg::CFG_PATTERN_0, w0);
        write_reg(wbss_pkg::CFG_PATTERN_1, w1);
        write_reg(wbss_pkg::CFG_PATTERN_2, w2);
        write_reg(wbss_pkg::CFG_PATTERN_3, w3);
        write_reg(wbss_pkg::CFG_CARE_MASK, {junk[63:32], mask});
        write_reg(wbss_pkg::CFG_LENGTH, {junk[63:6], len});
        write_reg(wbss_pkg::CFG_OFFSET, {junk[31:0], off});
        write_reg(wbss_pkg::CFG_REPORT_ALL, {junk[63:1], rep});
        i_cfg_we <= 1'b0;
        settings_run++;
    endtask

    initial begin
        int unsigned k;
        int unsigned j;
        int unsigned p;
        int unsigned n;
        int unsigned size;
        int unsigned copies;
        int unsigned phase_end;
        int unsigned rand_base;
        int unsigned phase_idx;
        int unsigned failures;
        logic [5:0]  len_pick;
        logic [31:0] mask_pick;
        logic [31:0] off_pick;
        logic [7:0]  byte_pick;

        sb           = new();
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tlast    = 1'b0;
        i_m_tready   = 1'b0;
        in_region    = 1'b0;
        burst_left   = 0;
        items_sent   = 0;
        regions_run  = 0;
        settings_run = 0;
        quiet_cycles = 0;
        rx_mode      = RX_FREE;
        rx_left      = 0;
        rx_tick      = 0;
        next_addr    = '0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values give a one-byte signature that is all wildcard.
        next_addr = '0;
        region_bytes = '{8'h00, 8'hFF};
        send_region(1'b1);
        // A match on the last byte of a region, at the top address.
        next_addr = '1;
        region_bytes = '{8'h5A};
        send_region(1'b1);

        // Length zero acts as one; a negative offset wraps below address zero.
        apply_config(64'hAB, '0, '0, '0, 32'h1, 6'd0, 32'hFFFF_FFFF, 1'b1);
        next_addr = '0;
        region_bytes = '{8'hAB, 8'h00, 8'hAB, 8'hAB};
        send_region(1'b1);
        region_bytes = '{8'h00, 8'hFF};
        send_region(1'b1);

        // Only mask bits past the length are set, so every byte is a wildcard.
        apply_config('0, '0, '0, '0, 32'hFFFF_FFFC, 6'd2, 32'h7FFF_FFFF, 1'b0);
        next_addr = '1;
        region_bytes = '{8'h12, 8'h34};
        send_region(1'b1);

        // An overlapping prefix must not hide the match; first-only mode.
        apply_config(64'hABAA, '0, '0, '0, 32'h3, 6'd2, 32'h8000_0000, 1'b0);
        next_addr = 48'h0000_0000_1000;
        region_bytes = '{8'hAA, 8'hAA, 8'hAB, 8'h00};
        send_region(1'b1);

        // Report-all keeps matches apart, then the signature changes mid-region.
        apply_config(64'hAAAA, '0, '0, '0, 32'h3, 6'd2, 32'h0, 1'b1);
        region_bytes = '{8'hAA, 8'hAA, 8'hAA, 8'hAA};
        send_region(1'b0);
        apply_config(64'h55AA, '0, '0, '0, 32'h3, 6'd2, 32'h0, 1'b1);
        region_bytes = '{8'h55, 8'hAA, 8'h55};
        send_region(1'b1);

        rand_base = items_sent;
        phase_idx = 0;
        while (items_sent - rand_base < RANDOM_ITEMS) begin
            case (phase_idx)
                0: len_pick = 6'd32;
                1: len_pick = 6'd63;
                2: len_pick = 6'd0;
                default: begin
                    k = $urandom_range(0, 9);
                    if (k < 6)       len_pick = 6'($urandom_range(1, 8));
                    else if (k < 8)  len_pick = 6'($urandom_range(9, 32));
                    else if (k == 8) len_pick = 6'd32;
                    else             len_pick = 6'($urandom_range(33, 63));
                end
            endcase
            case ($urandom_range(0, 5))
                0:       mask_pick = '1;
                1:       mask_pick = '0;
                2:       mask_pick = $urandom;
                3:       mask_pick = $urandom & $urandom;
                default: mask_pick = ~($urandom & $urandom);
            endcase
            case ($urandom_range(0, 4))
                0:       off_pick = '0;
                1:       off_pick = 32'h7FFF_FFFF;
                2:       off_pick = 32'h8000_0000;
                3:       off_pick = $urandom;
                default: off_pick = 32'($urandom_range(0, 64)) - 32'd32;
            endcase
            apply_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom}, mask_pick, len_pick, off_pick,
                         1'($urandom_range(0, 1)));
            phase_idx++;
            n = sb.eff_len();
            phase_end = items_sent + $urandom_range(30, 120);
            while (items_sent < phase_end) begin
                if (!in_region)
                    next_addr = ($urandom_range(0, 7) == 0)
                              ? {wbss_pkg::ADDRESS_BITS{1'b1}} - t_addr'($urandom_range(0, 40))
                              : {$urandom, 16'($urandom)};
                size = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4)
                                                   : n + $urandom_range(0, 24);
                // Noise leans on signature bytes so that partial matches are common.
                region_bytes.delete();
                for (k = 0; k < size; k++) begin
                    byte_pick = $urandom_range(0, 1) ? sb.sig_byte($urandom_range(0, n - 1))
                                                     : 8'($urandom);
                    region_bytes = {region_bytes, byte_pick};
                end
                if (size >= n && $urandom_range(0, 3) != 0) begin
                    copies = $urandom_range(1, 3);
                    for (k = 0; k < copies; k++) begin
                        p = $urandom_range(0, size - n);
                        for (j = 0; j < n; j++)
                            if (sb.care_bits[j]) region_bytes[p+j] = sb.sig_byte(j);
                        // Now and then one byte of the copy is spoilt.
                        if ($urandom_range(0, 3) == 0) begin
                            j = $urandom_range(0, n - 1);
                            region_bytes[p+j] = region_bytes[p+j] ^ 8'($urandom_range(1, 255));
                        end
                    end
                end
                // A region that reaches the end of the setting is sometimes left open.
                send_region((items_sent + size < phase_end) || ($urandom_range(0, 3) != 0));
            end
        end

        i_s_tvalid <= 1'b0;
        while (sb.owed_q.size() != 0) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);

        failures = sb.mismatches + sb.owed_q.size();
        $display("Scanned %0d bytes in %0d closed regions under %0d register settings.",
                 items_sent, regions_run, settings_run);
        $display("Checked %0d match results and %0d not-found results; %0d failures.",
                 sb.found_seen, sb.missing_seen, failures);
        if (failures == 0) begin
            $display("PASS wildcard_byte_signature_scan");
        end else begin
            $display("FAIL wildcard_byte_signature_scan");
        end
        $finish;
    end

endmodule
